### src/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the battery protection supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int TEMP_W   = 12;
    localparam int VOLT_W   = 14;
    localparam int PER_W    = 4;
    localparam int FAULT_W  = 16;
    localparam int STAT_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [STAT_W-1:0] ST_NORMAL    = 3'd0;
    localparam logic [STAT_W-1:0] ST_TEMP_HIGH = 3'd1;
    localparam logic [STAT_W-1:0] ST_TEMP_LOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_VOLT_HIGH = 3'd3;
    localparam logic [STAT_W-1:0] ST_VOLT_LOW  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CUTOFF_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_NO_CHARGE_LOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CUTOFF_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_FULL_MV       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW_MV        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_EMPTY_MV      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_CHECK_PERIOD  = 3'd7;

    // temperature hysteresis in 0.1 C, voltage hysteresis in mV
    localparam logic signed [TEMP_W:0] TEMP_HYST = 13'sd50;
    localparam logic [VOLT_W:0]        VOLT_HYST = 15'd300;
    localparam logic [FAULT_W-1:0]     FAULT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_cutoff_high;
        logic signed [TEMP_W-1:0] temp_warn_high;
        logic signed [TEMP_W-1:0] temp_no_charge_low;
        logic signed [TEMP_W-1:0] temp_cutoff_low;
        logic [VOLT_W-1:0]        volt_full_mv;
        logic [VOLT_W-1:0]        volt_low_mv;
        logic [VOLT_W-1:0]        volt_empty_mv;
        logic [PER_W-1:0]         volt_check_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        temp_cutoff_high:   12'sd600,
        temp_warn_high:     12'sd500,
        temp_no_charge_low: 12'sd0,
        temp_cutoff_low:    -12'sd100,
        volt_full_mv:       14'd8400,
        volt_low_mv:        14'd6600,
        volt_empty_mv:      14'd6000,
        volt_check_period:  4'd5
    };

    typedef struct packed {
        logic                charge_enable;
        logic                discharge_enable;
        logic [STAT_W-1:0]   battery_status;
        logic [FAULT_W-1:0]  fault_counter;
        logic [PER_W-1:0]    tick_counter;
    } state_t;

    localparam state_t STATE_RESET = '{
        charge_enable:    1'b1,
        discharge_enable: 1'b1,
        battery_status:   ST_NORMAL,
        fault_counter:    '0,
        tick_counter:     '0
    };

    // packed so that status_code lands in the lowest bits
    typedef struct packed {
        logic               volt_checked;
        logic               volt_critical_alarm;
        logic               temp_warning_alarm;
        logic               temp_critical_alarm;
        logic [FAULT_W-1:0] faults_seen;
        logic               discharge_allowed;
        logic               charge_allowed;
        logic [STAT_W-1:0]  status_code;
    } result_t;

endpackage

`default_nettype wire

### src/bps_cfg_regs.sv
// ----------------------------------------------------------------------------
// bps_cfg_regs
// Limit and period registers, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bps_pkg::cfg_t                          cfg
);
    import bps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_CUTOFF_HIGH:   cfg_next.temp_cutoff_high   = cfg_data[TEMP_W-1:0];
                REG_TEMP_WARN_HIGH:     cfg_next.temp_warn_high     = cfg_data[TEMP_W-1:0];
                REG_TEMP_NO_CHARGE_LOW: cfg_next.temp_no_charge_low = cfg_data[TEMP_W-1:0];
                REG_TEMP_CUTOFF_LOW:    cfg_next.temp_cutoff_low    = cfg_data[TEMP_W-1:0];
                REG_VOLT_FULL_MV:       cfg_next.volt_full_mv       = cfg_data[VOLT_W-1:0];
                REG_VOLT_LOW_MV:        cfg_next.volt_low_mv        = cfg_data[VOLT_W-1:0];
                REG_VOLT_EMPTY_MV:      cfg_next.volt_empty_mv      = cfg_data[VOLT_W-1:0];
                REG_VOLT_CHECK_PERIOD:  cfg_next.volt_check_period  = cfg_data[PER_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/bps_eval.sv
// ----------------------------------------------------------------------------
// bps_eval
// One tick of protection logic: temperature checks, periodic voltage check,
// status merge, next supervisor state and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_eval (
    input  wire bps_pkg::cfg_t                     cfg,
    input  wire bps_pkg::state_t                   state,
    input  wire logic signed [bps_pkg::TEMP_W-1:0] temp_tenths_c,
    input  wire logic [bps_pkg::VOLT_W-1:0]        volt_mv,
    output bps_pkg::state_t                        state_next,
    output bps_pkg::result_t                       result
);
    import bps_pkg::*;

    logic signed [TEMP_W:0] t_ext;
    logic signed [TEMP_W:0] rec_hi;
    logic signed [TEMP_W:0] rec_lo;
    logic [VOLT_W:0]        v_rec;
    logic [PER_W-1:0]       tick_inc;
    logic [STAT_W-1:0]      t_stat;
    logic [STAT_W-1:0]      v_stat;
    logic                   chg;
    logic                   dis;
    logic [FAULT_W-1:0]     faults;
    logic                   a_tcrit;
    logic                   a_twarn;
    logic                   a_vcrit;
    logic                   checked;
    logic [PER_W-1:0]       tick;

    always_comb
    begin
        t_ext       = {temp_tenths_c[TEMP_W-1], temp_tenths_c};
        rec_hi      = {cfg.temp_warn_high[TEMP_W-1], cfg.temp_warn_high} - TEMP_HYST;
        rec_lo      = {cfg.temp_no_charge_low[TEMP_W-1], cfg.temp_no_charge_low} + TEMP_HYST;
        v_rec       = {1'b0, cfg.volt_low_mv} + VOLT_HYST;
        chg         = state.charge_enable;
        dis         = state.discharge_enable;
        faults      = state.fault_counter;
        t_stat      = ST_NORMAL;
        v_stat      = ST_NORMAL;
        a_tcrit     = 1'b0;
        a_twarn     = 1'b0;
        a_vcrit     = 1'b0;
        checked     = 1'b0;

        if (temp_tenths_c >= cfg.temp_cutoff_high)
        begin
            chg         = 1'b0;
            dis         = 1'b0;
            if (faults != FAULT_MAX)
                faults = faults + 1'b1;
            a_tcrit     = 1'b1;
            t_stat      = ST_TEMP_HIGH;
        end
        else if (temp_tenths_c >= cfg.temp_warn_high)
        begin
            chg         = 1'b0;
            a_twarn     = 1'b1;
            t_stat      = ST_TEMP_HIGH;
        end
        else if (temp_tenths_c <= cfg.temp_cutoff_low)
        begin
            chg         = 1'b0;
            dis         = 1'b0;
            t_stat      = ST_TEMP_LOW;
        end
        else if (temp_tenths_c <= cfg.temp_no_charge_low)
        begin
            chg         = 1'b0;
            t_stat      = ST_TEMP_LOW;
        end
        else if (state.battery_status == ST_TEMP_HIGH || state.battery_status == ST_TEMP_LOW)
        begin
            if (t_ext < rec_hi && t_ext > rec_lo)
            begin
                chg    = 1'b1;
                dis    = 1'b1;
                faults = '0;
            end
        end

        tick_inc = state.tick_counter + 1'b1;
        tick     = tick_inc;
        if (tick_inc >= cfg.volt_check_period)
        begin
            checked = 1'b1;
            tick    = '0;
            if (volt_mv >= cfg.volt_full_mv)
            begin
                chg         = 1'b0;
                v_stat      = ST_VOLT_HIGH;
            end
            else if (volt_mv <= cfg.volt_empty_mv)
            begin
                dis         = 1'b0;
                a_vcrit     = 1'b1;
                v_stat      = ST_VOLT_LOW;
            end
            else if (volt_mv <= cfg.volt_low_mv)
            begin
                v_stat      = ST_VOLT_LOW;
            end
            else if (state.battery_status == ST_VOLT_LOW && {1'b0, volt_mv} >= v_rec)
            begin
                dis = 1'b1;
            end
        end

        state_next.charge_enable    = chg;
        state_next.discharge_enable = dis;
        state_next.battery_status   = (v_stat != ST_NORMAL) ? v_stat : t_stat;
        state_next.fault_counter    = faults;
        state_next.tick_counter     = tick;

        result.status_code         = state_next.battery_status;
        result.charge_allowed      = chg;
        result.discharge_allowed   = dis;
        result.faults_seen         = faults;
        result.temp_critical_alarm = a_tcrit;
        result.temp_warning_alarm  = a_twarn;
        result.volt_critical_alarm = a_vcrit;
        result.volt_checked        = checked;
    end

endmodule

`default_nettype wire

### src/battery_protection_supervisor_top.sv
// ----------------------------------------------------------------------------
// battery_protection_supervisor_top
// An accepted input is held in the input register, then its result in the
//   result register. Throughput: one item per cycle while m_tready is high.
// The state update for an item happens as it moves into the result register.
// Reset (rst_n, async, active low): limits to defaults, enables set,
//   status normal, fault and tick counters cleared, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_protection_supervisor_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [11:0] temp_tenths_c, [25:12] volt_mv, [31:26] zero
    input  wire logic [bps_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [2:0] status_code, [3] charge_allowed, [4] discharge_allowed,
    // [20:5] faults_seen, [21] temp_critical_alarm, [22] temp_warning_alarm,
    // [23] volt_critical_alarm, [24] volt_checked, [31:25] zero
    output logic [bps_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bps_pkg::*;

    cfg_t                     cfg;
    state_t                   state_reg;
    state_t                   state_next;
    result_t                  result;
    result_t                  res_reg;
    logic                     res_valid_reg;
    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [VOLT_W-1:0]        volt_reg;
    logic                     advance;
    logic                     in_fire;

    bps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bps_eval u_eval (
        .cfg           (cfg),
        .state         (state_reg),
        .temp_tenths_c (temp_reg),
        .volt_mv       (volt_reg),
        .state_next    (state_next),
        .result        (result)
    );

    assign advance  = in_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            temp_reg <= s_tdata[TEMP_W-1:0];
            volt_reg <= s_tdata[TEMP_W+VOLT_W-1:TEMP_W];
        end
        if (advance)
            res_reg <= result;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, res_reg};

endmodule

`default_nettype wire
